@@ rtl/core/iafs_pkg.sv @@
// ----------------------------------------------------------------------------
// iafs_pkg
// Shared types and constants for the slot index allocator.
// ----------------------------------------------------------------------------
package iafs_pkg;

    localparam int CAPACITY    = 1024;
    localparam int INDEX_SPACE = 1024;
    localparam int LIMIT_MAX   = (CAPACITY < INDEX_SPACE) ? CAPACITY : INDEX_SPACE;

    localparam int IDX_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int STRIDE_W = 13;
    localparam int ADDR_W   = 64;
    localparam int CAP_AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DEPTH_W  = $clog2(CAPACITY + 1);
    localparam int OFFS_W   = STRIDE_W + IDX_W;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CAPACITY  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;
    localparam logic [1:0] STATUS_RANGE     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [IDX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic [ADDR_W-1:0] cpu_address;
        logic [ADDR_W-1:0] gpu_address;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic              rd;
        logic [CAP_AW-1:0] rd_addr;
        logic              wr;
        logic [CAP_AW-1:0] wr_addr;
        logic              wr_bit;
    } bm_req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

@@ rtl/core/index_allocator_free_stack_top.sv @@
// ----------------------------------------------------------------------------
// index_allocator_free_stack_top
// Slot index allocator: LIFO free stack plus bump pointer, with range and
// in-use checks and base + stride * index address lookup.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  req     | req_valid, req_ready, req            | func, slot_index
//  rsp     | rsp_valid, rsp_ready, rsp            | granted_index, addresses,
//          |                                      | status
//  cfg     | cfg_valid, cfg_ready, cfg_index,     | register writes
//          | cfg_data                             |
//
//  For each item the accept cycle issues the reads of the free stack and the
//  in-use bitmap, and the execute state uses the registered read data,
//  writes back and loads the result register.
//  After reset a clearing sweep writes every entry of the bitmap to zero;
//  req_ready stays low meanwhile, configuration writes are taken as usual.
//  A new request is taken while a finished result waits; if the result
//  register is still occupied, the execute cycle holds until it drains.
//
module index_allocator_free_stack_top (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             req_valid,
    output logic                             req_ready,
    input  iafs_pkg::req_t                   req,

    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output iafs_pkg::rsp_t                   rsp,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iafs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iafs_pkg::ADDR_W-1:0]      cfg_data
);

    // ---- configuration registers ----
    logic [iafs_pkg::COUNT_W-1:0]  slot_count_reg;
    logic [iafs_pkg::STRIDE_W-1:0] slot_stride_reg;
    logic [iafs_pkg::ADDR_W-1:0]   cpu_base_reg;
    logic [iafs_pkg::ADDR_W-1:0]   gpu_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= iafs_pkg::COUNT_W'(1024);
            slot_stride_reg <= iafs_pkg::STRIDE_W'(32);
            cpu_base_reg    <= '0;
            gpu_base_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                iafs_pkg::CFG_SLOT_COUNT:
                    slot_count_reg  <= cfg_data[iafs_pkg::COUNT_W-1:0];
                iafs_pkg::CFG_SLOT_STRIDE:
                    slot_stride_reg <= cfg_data[iafs_pkg::STRIDE_W-1:0];
                iafs_pkg::CFG_CPU_BASE:
                    cpu_base_reg    <= cfg_data;
                iafs_pkg::CFG_GPU_BASE:
                    gpu_base_reg    <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // ---- control state ----
    iafs_pkg::state_t              state_reg, state_next;
    logic [iafs_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [iafs_pkg::COUNT_W-1:0]  fresh_reg, fresh_next;
    iafs_pkg::req_t                item_reg;
    logic                          rsp_valid_reg, rsp_valid_next;
    iafs_pkg::rsp_t                rsp_reg, rsp_next;

    logic clear_busy;
    logic req_xfer;
    logic exec_go;

    assign req_ready = (state_reg == iafs_pkg::ST_IDLE) && !clear_busy;
    assign req_xfer  = req_valid && req_ready;
    assign exec_go   = (state_reg == iafs_pkg::ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // ---- memories ----
    iafs_pkg::bm_req_t              bm_req;
    logic                           bm_bit;

    logic                           stk_wr;
    logic [iafs_pkg::CAP_AW-1:0]    stk_wr_addr;
    logic [iafs_pkg::IDX_W-1:0]     stk_wr_data;
    logic [iafs_pkg::CAP_AW-1:0]    stk_rd_addr;
    logic [iafs_pkg::IDX_W-1:0]     stk_rd_data;

    iafs_bitmap u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (bm_req),
        .rd_bit (bm_bit),
        .busy   (clear_busy)
    );

    iafs_ram #(
        .ADDR_BITS (iafs_pkg::CAP_AW),
        .DATA_BITS (iafs_pkg::IDX_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (req_xfer),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // top of stack read at accept; garbage when empty and then unused
    assign stk_rd_addr = iafs_pkg::CAP_AW'(depth_reg - iafs_pkg::DEPTH_W'(1));

    // ---- execute ----
    logic [iafs_pkg::COUNT_W-1:0]  limit;
    logic                          in_range;
    logic [iafs_pkg::OFFS_W-1:0]   offset;

    assign limit = (slot_count_reg > iafs_pkg::COUNT_W'(iafs_pkg::LIMIT_MAX))
                   ? iafs_pkg::COUNT_W'(iafs_pkg::LIMIT_MAX) : slot_count_reg;
    assign in_range = iafs_pkg::COUNT_W'(item_reg.slot_index) < limit;
    assign offset   = iafs_pkg::OFFS_W'(slot_stride_reg)
                    * iafs_pkg::OFFS_W'(item_reg.slot_index);

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        bm_req.rd      = req_xfer;
        bm_req.rd_addr = iafs_pkg::CAP_AW'(req.slot_index);
        bm_req.wr      = 1'b0;
        bm_req.wr_addr = iafs_pkg::CAP_AW'(item_reg.slot_index);
        bm_req.wr_bit  = 1'b0;

        stk_wr      = 1'b0;
        stk_wr_addr = iafs_pkg::CAP_AW'(depth_reg);
        stk_wr_data = item_reg.slot_index;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_xfer)
        begin
            state_next = iafs_pkg::ST_EXEC;
        end

        if (exec_go)
        begin
            state_next             = iafs_pkg::ST_IDLE;
            rsp_valid_next         = 1'b1;
            rsp_next.granted_index = item_reg.slot_index;
            rsp_next.cpu_address   = '0;
            rsp_next.gpu_address   = '0;
            rsp_next.status        = iafs_pkg::STATUS_OK;

            case (item_reg.func)
                iafs_pkg::FUNC_ALLOC:
                begin
                    if (depth_reg != '0)
                    begin
                        // pop the most recently freed slot
                        depth_next             = depth_reg - iafs_pkg::DEPTH_W'(1);
                        rsp_next.granted_index = stk_rd_data;
                        bm_req.wr              = 1'b1;
                        bm_req.wr_addr         = iafs_pkg::CAP_AW'(stk_rd_data);
                        bm_req.wr_bit          = 1'b1;
                    end
                    else if (fresh_reg < limit)
                    begin
                        fresh_next             = fresh_reg + iafs_pkg::COUNT_W'(1);
                        rsp_next.granted_index = iafs_pkg::IDX_W'(fresh_reg);
                        bm_req.wr              = 1'b1;
                        bm_req.wr_addr         = iafs_pkg::CAP_AW'(fresh_reg);
                        bm_req.wr_bit          = 1'b1;
                    end
                    else
                    begin
                        rsp_next.granted_index = '0;
                        rsp_next.status        = iafs_pkg::STATUS_CAPACITY;
                    end
                end
                iafs_pkg::FUNC_FREE:
                begin
                    if (!in_range || !bm_bit)
                    begin
                        rsp_next.status = iafs_pkg::STATUS_BAD_FREE;
                    end
                    else
                    begin
                        bm_req.wr = 1'b1;
                        // full stack drops the push
                        if (depth_reg < iafs_pkg::DEPTH_W'(iafs_pkg::CAPACITY))
                        begin
                            stk_wr     = 1'b1;
                            depth_next = depth_reg + iafs_pkg::DEPTH_W'(1);
                        end
                    end
                end
                iafs_pkg::FUNC_LOOKUP:
                begin
                    if (!in_range)
                    begin
                        rsp_next.status = iafs_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        rsp_next.cpu_address = cpu_base_reg + iafs_pkg::ADDR_W'(offset);
                        rsp_next.gpu_address = gpu_base_reg + iafs_pkg::ADDR_W'(offset);
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iafs_pkg::ST_IDLE;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/iafs_ram.sv @@
// ----------------------------------------------------------------------------
// iafs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module iafs_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/iafs_bitmap.sv @@
// ----------------------------------------------------------------------------
// iafs_bitmap
// In-use bitmap memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module iafs_bitmap (
    input  logic                clk,
    input  logic                rst_n,
    input  iafs_pkg::bm_req_t   req,
    output logic                rd_bit,
    output logic                busy
);

    logic                        clearing_reg;
    logic [iafs_pkg::CAP_AW-1:0] clr_addr_reg;
    logic [iafs_pkg::CAP_AW-1:0] clr_addr_next;

    logic                        wr_en;
    logic [iafs_pkg::CAP_AW-1:0] wr_addr;
    logic                        wr_bit;

    assign clr_addr_next = clr_addr_reg + iafs_pkg::CAP_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_next;
            if (clr_addr_reg == iafs_pkg::CAP_AW'(iafs_pkg::CAPACITY - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // sweep owns the write port while it runs
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_bit  = 1'b0;
        end
        else
        begin
            wr_en   = req.wr;
            wr_addr = req.wr_addr;
            wr_bit  = req.wr_bit;
        end
    end

    iafs_ram #(
        .ADDR_BITS (iafs_pkg::CAP_AW),
        .DATA_BITS (1)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_bit),
        .rd_en   (req.rd),
        .rd_addr (req.rd_addr),
        .rd_data (rd_bit)
    );

    assign busy = clearing_reg;

endmodule
